// ===== hdl/mft_pkg.sv =====
// shared types, constants and field layouts for the multi-turn tracker
package mft_pkg;

    localparam int MOTOR_COUNT_DEF = 8;
    localparam int TURN_BITS_DEF   = 16;

    // small queue between the classifier and the tracker pipeline
    localparam int QUEUE_DEPTH = 4;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 136;
    localparam int SLOT_W    = 3;
    localparam int SHAFT_W   = 38;
    localparam int TICKS_OUT_W = 30;
    localparam int GEAR_W    = 8;

    localparam logic [10:0] FEEDBACK_BASE_ID = 11'h201;
    localparam int HALF_TURN  = 4096;
    localparam int TICK_BITS  = 13;

    // constant divider by 19, one byte of dividend per stage
    localparam int DIGIT_W    = 8;
    localparam int DIV_RATIO  = 19;
    localparam int REM_W      = 5;
    localparam int DIV_RECIP  = 6899;
    localparam int RECIP_W    = 13;
    localparam int DIV_SHIFT  = 17;

    localparam logic [1:0] FUNC_FEEDBACK = 2'd0;
    localparam logic [1:0] FUNC_CAPTURE  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR    = 2'd2;

    typedef enum logic [1:0] {
        OP_FEEDBACK,
        OP_CAPTURE,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [2:0]  slot;
        logic [15:0] angle;
        logic [15:0] speed;
        logic [15:0] current;
    } q_entry_t;

    typedef struct packed {
        logic [2:0]  slot;
        logic [15:0] angle;
        logic [15:0] speed;
        logic [15:0] current;
        logic [15:0] turn_count;
        logic [29:0] ticks;
        logic        neg;
    } side_t;

endpackage

// ===== hdl/motor_feedback_multiturn_tracker.sv =====
// top level of the multi-turn tracker: stream ports, front end, queue and tracker pipeline
//
//  channel | direction | handshake             | contents
//  --------+-----------+-----------------------+-----------------------------------------
//  s_      | in        | s_tvalid / s_tready   | feedback frame, capture or clear event
//  m_      | out       | m_tvalid / m_tready   | decoded feedback with turns, ticks, angle
//  cfg_    | in        | cfg_we                | gear_type_mask, bit i selects ratio 36
//
//  one word per cycle in and out unless m_tready or a full queue stalls; a taken word goes
//  through the queue, stages 1 to 4, NDIG = ceil((TURN_BITS + 26) / 8) stages of the
//  byte-wise divide by 19 and the output register; the per-motor state update sits in one stage
//  reset clears the per-motor state, the gear mask, the queue and all valid flags
//  m_tready low while m_tvalid is high freezes the pipeline; the four-entry queue keeps
//  s_tready high until it fills, and capture, clear and unknown-id words never reach m_
module motor_feedback_multiturn_tracker #(
    parameter int MOTOR_COUNT = mft_pkg::MOTOR_COUNT_DEF,
    parameter int TURN_BITS   = mft_pkg::TURN_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [mft_pkg::GEAR_W-1:0]    cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // frame_id, motor_index, byte0, byte1, byte2, byte3, byte4, byte5, zero pad
    input  logic [mft_pkg::S_TDATA_W-1:0] s_tdata,
    // func
    input  logic [mft_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // motor_slot, encoder_angle, speed_rpm, motor_current, turn_count,
    // multi_turn_ticks, shaft_angle_q16, zero pad
    output logic [mft_pkg::M_TDATA_W-1:0] m_tdata
);

    logic                        keep;
    logic                        push;
    logic                        q_full;
    logic                        q_pop;
    logic                        head_valid;
    mft_pkg::q_entry_t           push_entry;
    mft_pkg::q_entry_t           head;
    mft_pkg::side_t              out_side;
    logic [mft_pkg::SHAFT_W-1:0] out_shaft;

    mft_front #(
        .MOTOR_COUNT(MOTOR_COUNT)
    ) u_front (
        .func        (s_tuser),
        .frame_id    (s_tdata[10:0]),
        .motor_index (s_tdata[13:11]),
        .payload     ({s_tdata[53:46], s_tdata[61:54],
                       s_tdata[37:30], s_tdata[45:38],
                       s_tdata[21:14], s_tdata[29:22]}),
        .keep        (keep),
        .entry       (push_entry)
    );

    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready && keep;

    mft_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    mft_back #(
        .MOTOR_COUNT(MOTOR_COUNT),
        .TURN_BITS  (TURN_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .head_valid (head_valid),
        .head       (head),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_side   (out_side),
        .out_shaft  (out_shaft)
    );

    assign m_tdata = {1'b0, out_shaft, out_side.ticks, out_side.turn_count,
                      out_side.current, out_side.speed, out_side.angle, out_side.slot};

endmodule

// ===== hdl/mft_front.sv =====
// front end: decodes func and identifier, turns a word into a queue entry or drops it
module mft_front #(
    parameter int MOTOR_COUNT = mft_pkg::MOTOR_COUNT_DEF
) (
    input  logic [1:0]       func,
    input  logic [10:0]      frame_id,
    input  logic [2:0]       motor_index,
    input  logic [47:0]      payload,
    output logic             keep,
    output mft_pkg::q_entry_t entry
);

    logic [10:0] id_off;
    logic        fb_ok;
    logic        mi_ok;

    assign id_off = frame_id - mft_pkg::FEEDBACK_BASE_ID;
    assign fb_ok  = (frame_id >= mft_pkg::FEEDBACK_BASE_ID) && (id_off < 11'(MOTOR_COUNT));
    assign mi_ok  = {1'b0, motor_index} < 4'(MOTOR_COUNT);

    always_comb begin
        entry.angle   = payload[15:0];
        entry.speed   = payload[31:16];
        entry.current = payload[47:32];
        entry.slot    = motor_index;
        entry.op      = mft_pkg::OP_FEEDBACK;
        keep          = 1'b0;
        unique case (func)
            mft_pkg::FUNC_FEEDBACK: begin
                entry.op   = mft_pkg::OP_FEEDBACK;
                entry.slot = id_off[2:0];
                keep       = fb_ok;
            end
            mft_pkg::FUNC_CAPTURE: begin
                entry.op = mft_pkg::OP_CAPTURE;
                keep     = mi_ok;
            end
            mft_pkg::FUNC_CLEAR: begin
                entry.op = mft_pkg::OP_CLEAR;
                keep     = mi_ok;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/mft_queue.sv =====
// short fifo of classified entries between front end and tracker pipeline
module mft_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  mft_pkg::q_entry_t push_entry,
    input  logic              pop,
    output logic              full,
    output logic              head_valid,
    output mft_pkg::q_entry_t head
);

    localparam int DEPTH = mft_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mft_pkg::q_entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hdl/mft_div19.sv =====
// pipelined divide by 19, one dividend byte per stage, sideband carried alongside
module mft_div19 #(
    parameter int XW = 42
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_vld,
    input  logic [XW-1:0]         in_x,
    input  mft_pkg::side_t        in_side,
    output logic                  out_vld,
    output logic [((XW + mft_pkg::DIGIT_W - 1) / mft_pkg::DIGIT_W) * mft_pkg::DIGIT_W - 1:0] out_q,
    output mft_pkg::side_t        out_side
);

    localparam int DW    = mft_pkg::DIGIT_W;
    localparam int NDIG  = (XW + DW - 1) / DW;
    localparam int PW    = NDIG * DW;
    localparam int RW    = mft_pkg::REM_W;
    localparam int VW    = RW + DW;
    localparam int PRODW = VW + mft_pkg::RECIP_W;

    logic                 vld_reg  [NDIG];
    logic [RW-1:0]        rem_reg  [NDIG];
    logic [PW-1:0]        x_reg    [NDIG];
    logic [PW-1:0]        q_reg    [NDIG];
    mft_pkg::side_t       side_reg [NDIG];

    for (genvar k = 0; k < NDIG; k++) begin : g_stage
        logic                 vld_in;
        logic [RW-1:0]        rem_in;
        logic [PW-1:0]        x_in;
        logic [PW-1:0]        q_in;
        mft_pkg::side_t       side_in;
        logic [VW-1:0]        v;
        logic [PRODW-1:0]     prod;
        logic [DW-1:0]        qe;
        logic [VW-1:0]        r;
        logic [DW-1:0]        qd_next;
        logic [VW-1:0]        rd_next;
        logic [PW-1:0]        q_next;

        if (k == 0) begin : g_first
            assign vld_in  = in_vld;
            assign rem_in  = '0;
            assign x_in    = PW'(in_x);
            assign q_in    = '0;
            assign side_in = in_side;
        end else begin : g_rest
            assign vld_in  = vld_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign x_in    = x_reg[k-1];
            assign q_in    = q_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // v stays below 19*256, so the reciprocal estimate is exact there
        assign v    = {rem_in, x_in[PW-1-k*DW -: DW]};
        assign prod = PRODW'(v) * PRODW'(mft_pkg::DIV_RECIP);
        assign qe   = prod[mft_pkg::DIV_SHIFT +: DW];
        assign r    = v - ((VW'(qe) << 4) + (VW'(qe) << 1) + VW'(qe));

        always_comb begin
            qd_next = qe;
            rd_next = r;
            if (r >= VW'(mft_pkg::DIV_RATIO)) begin
                qd_next = qe + 1'b1;
                rd_next = r - VW'(mft_pkg::DIV_RATIO);
            end
            q_next = q_in;
            q_next[PW-1-k*DW -: DW] = qd_next;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rd_next[RW-1:0];
                x_reg[k]    <= x_in;
                q_reg[k]    <= q_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_vld  = vld_reg[NDIG-1];
    assign out_q    = q_reg[NDIG-1];
    assign out_side = side_reg[NDIG-1];

endmodule

// ===== hdl/mft_back.sv =====
// back end: per-motor state update, tick count, shaft angle and output register
module mft_back #(
    parameter int MOTOR_COUNT = mft_pkg::MOTOR_COUNT_DEF,
    parameter int TURN_BITS   = mft_pkg::TURN_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [mft_pkg::GEAR_W-1:0] cfg_wdata,
    input  logic                      head_valid,
    input  mft_pkg::q_entry_t         head,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output mft_pkg::side_t            out_side,
    output logic [mft_pkg::SHAFT_W-1:0] out_shaft
);

    localparam int TB      = TURN_BITS;
    localparam int IDX_W   = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
    localparam int TICKS_W = TB + 14;
    localparam int XW      = TICKS_W + 12;
    localparam int NDIG    = (XW + mft_pkg::DIGIT_W - 1) / mft_pkg::DIGIT_W;
    localparam int PW      = NDIG * mft_pkg::DIGIT_W;

    localparam logic signed [TB-1:0] T_MAX = {1'b0, {(TB-1){1'b1}}};
    localparam logic signed [TB-1:0] T_MIN = {1'b1, {(TB-1){1'b0}}};

    logic                    adv;
    logic [IDX_W-1:0]        idx;

    logic [mft_pkg::GEAR_W-1:0] gear_reg;
    logic [15:0]             prev_reg   [MOTOR_COUNT];
    logic signed [TB-1:0]    turns_reg  [MOTOR_COUNT];
    logic [15:0]             offset_reg [MOTOR_COUNT];

    logic [15:0]             prev_rd;
    logic signed [TB-1:0]    t_rd;
    logic signed [16:0]      d;
    logic signed [TB-1:0]    t_next;
    logic [63:0]             t_ext;

    // stage 1: updated turns and offset
    logic                    s1_vld_reg;
    logic signed [TB-1:0]    s1_t_reg;
    logic [15:0]             s1_off_reg;
    logic                    s1_r36_reg;
    mft_pkg::side_t          s1_side_reg;
    logic signed [TICKS_W-1:0] s1_turn_ext, s1_ang_ext, s1_off_ext, ticks_next;
    logic [63:0]             ticks_ext;

    // stage 2: signed tick count
    logic                    s2_vld_reg;
    logic signed [TICKS_W-1:0] s2_ticks_reg;
    logic                    s2_r36_reg;
    mft_pkg::side_t          s2_side_reg;
    mft_pkg::side_t          s2_side_next;
    logic                    neg_next;
    logic [TICKS_W-1:0]      mag_next;

    // stage 3: magnitude
    logic                    s3_vld_reg;
    logic [TICKS_W-1:0]      s3_mag_reg;
    logic                    s3_r36_reg;
    mft_pkg::side_t          s3_side_reg;
    mft_pkg::side_t          s3_side_next;
    logic [XW-1:0]           mag_x;
    logic [XW-1:0]           x_next;

    // stage 4: dividend for the divide by 19
    logic                    s4_vld_reg;
    logic [XW-1:0]           s4_x_reg;
    mft_pkg::side_t          s4_side_reg;

    logic                    dv_vld;
    logic [PW-1:0]           dv_q;
    mft_pkg::side_t          dv_side;
    logic [63:0]             q_ext;
    logic [63:0]             shaft_next;

    logic                    out_valid_reg;
    mft_pkg::side_t          out_side_reg;
    logic [mft_pkg::SHAFT_W-1:0] out_shaft_reg;

    assign adv = !out_valid_reg || out_ready;
    assign pop = head_valid && adv;
    assign idx = head.slot[IDX_W-1:0];

    // unwrap against the last angle of this motor, saturating turn count
    assign prev_rd = prev_reg[idx];
    assign t_rd    = turns_reg[idx];
    assign d       = $signed({1'b0, head.angle}) - $signed({1'b0, prev_rd});

    always_comb begin
        t_next = t_rd;
        if (d > $signed(17'(mft_pkg::HALF_TURN))) begin
            if (t_rd != T_MIN) begin
                t_next = t_rd - 1'b1;
            end
        end else if (d < -$signed(17'(mft_pkg::HALF_TURN))) begin
            if (t_rd != T_MAX) begin
                t_next = t_rd + 1'b1;
            end
        end
    end

    assign t_ext = 64'(t_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gear_reg <= '0;
        end else if (cfg_we) begin
            gear_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MOTOR_COUNT; i++) begin
                prev_reg[i]   <= '0;
                turns_reg[i]  <= '0;
                offset_reg[i] <= '0;
            end
        end else if (pop) begin
            unique case (head.op)
                mft_pkg::OP_FEEDBACK: begin
                    prev_reg[idx]  <= head.angle;
                    turns_reg[idx] <= t_next;
                end
                mft_pkg::OP_CAPTURE: begin
                    offset_reg[idx] <= prev_rd;
                    turns_reg[idx]  <= '0;
                end
                mft_pkg::OP_CLEAR: begin
                    turns_reg[idx] <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // stage 1
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (adv) begin
            s1_vld_reg <= pop && (head.op == mft_pkg::OP_FEEDBACK);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_t_reg               <= t_next;
            s1_off_reg             <= offset_reg[idx];
            s1_r36_reg             <= gear_reg[head.slot];
            s1_side_reg.slot       <= head.slot;
            s1_side_reg.angle      <= head.angle;
            s1_side_reg.speed      <= head.speed;
            s1_side_reg.current    <= head.current;
            s1_side_reg.turn_count <= t_ext[15:0];
            s1_side_reg.ticks      <= '0;
            s1_side_reg.neg        <= 1'b0;
        end
    end

    // ticks = turns * 8192 + angle - offset
    assign s1_turn_ext = TICKS_W'(s1_t_reg);
    assign s1_ang_ext  = TICKS_W'(s1_side_reg.angle);
    assign s1_off_ext  = TICKS_W'(s1_off_reg);
    assign ticks_next  = (s1_turn_ext <<< mft_pkg::TICK_BITS) + s1_ang_ext - s1_off_ext;
    assign ticks_ext   = 64'(ticks_next);

    always_comb begin
        s2_side_next       = s1_side_reg;
        s2_side_next.ticks = ticks_ext[mft_pkg::TICKS_OUT_W-1:0];
    end

    // stage 2
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (adv) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_ticks_reg <= ticks_next;
            s2_r36_reg   <= s1_r36_reg;
            s2_side_reg  <= s2_side_next;
        end
    end

    assign neg_next = s2_ticks_reg[TICKS_W-1];
    assign mag_next = neg_next ? TICKS_W'(-s2_ticks_reg) : TICKS_W'(s2_ticks_reg);

    always_comb begin
        s3_side_next     = s2_side_reg;
        s3_side_next.neg = neg_next;
    end

    // stage 3
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_vld_reg <= 1'b0;
        end else if (adv) begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_mag_reg  <= mag_next;
            s3_r36_reg  <= s2_r36_reg;
            s3_side_reg <= s3_side_next;
        end
    end

    // ratio 19: |ticks|*2880 / 19; ratio 36: |ticks|*80 = |ticks|*1520 / 19
    assign mag_x = XW'(s3_mag_reg);

    always_comb begin
        if (s3_r36_reg) begin
            x_next = (mag_x << 10) + (mag_x << 8) + (mag_x << 7) + (mag_x << 6)
                   + (mag_x << 5) + (mag_x << 4);
        end else begin
            x_next = (mag_x << 11) + (mag_x << 9) + (mag_x << 8) + (mag_x << 6);
        end
    end

    // stage 4
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_vld_reg <= 1'b0;
        end else if (adv) begin
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_x_reg    <= x_next;
            s4_side_reg <= s3_side_reg;
        end
    end

    mft_div19 #(
        .XW(XW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_vld   (s4_vld_reg),
        .in_x     (s4_x_reg),
        .in_side  (s4_side_reg),
        .out_vld  (dv_vld),
        .out_q    (dv_q),
        .out_side (dv_side)
    );

    // truncation toward zero: divide the magnitude, then restore the sign
    assign q_ext      = 64'(dv_q);
    assign shaft_next = dv_side.neg ? (64'd0 - q_ext) : q_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= dv_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_side_reg  <= dv_side;
            out_shaft_reg <= shaft_next[mft_pkg::SHAFT_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_side  = out_side_reg;
    assign out_shaft = out_shaft_reg;

endmodule

// ===== hdl/mft_checker.sv =====
// port-level checks for the multi-turn tracker and their bind to the top level
module mft_checker #(
    parameter int MOTOR_COUNT = mft_pkg::MOTOR_COUNT_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mft_pkg::M_TDATA_W-1:0] m_tdata
);

    // nothing is left in flight after reset
    a_reset_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    a_reset_in: assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("input not ready right after reset");

    // the queue only fills through an accepted word
    a_ready_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(s_tvalid && s_tready))
        else $error("s_tready dropped without an accepted word");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (4'(m_tdata[2:0]) < 4'(MOTOR_COUNT)))
        else $error("motor slot out of range");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

endmodule

bind motor_feedback_multiturn_tracker mft_checker #(
    .MOTOR_COUNT(MOTOR_COUNT)
) u_mft_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== dv/tb_motor_feedback_multiturn_tracker.sv =====
// testbench for the multi-turn tracker: directed, multi-turn, back-pressure and random traffic
module tb_motor_feedback_multiturn_tracker;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int MOTORS = mft_pkg::MOTOR_COUNT_DEF;
    localparam int TURN_MAX = (1 << (mft_pkg::TURN_BITS_DEF - 1)) - 1;
    localparam int TURN_MIN = -TURN_MAX - 1;
    localparam int TICKS_PER_TURN = 8192;
    localparam int DEG_Q16_PER_TICK = 2880;
    localparam int RATIO_LOW = 19;
    localparam int RATIO_HIGH = 36;
    // settle after the last expected result before touching the register
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_PHASE_WORDS = 225;
    localparam int TURN_RUN = 20;

    typedef struct {
        logic [2:0]  slot;
        logic [15:0] angle;
        logic [15:0] speed;
        logic [15:0] current;
        logic [15:0] turn_count;
        logic [29:0] ticks;
        logic [37:0] shaft;
    } fb_result_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [mft_pkg::GEAR_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [mft_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [mft_pkg::S_TUSER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [mft_pkg::M_TDATA_W-1:0] m_tdata;

    // tracker state mirrored by the testbench
    logic [15:0] angle_seen [MOTORS];
    int          turn_cnt   [MOTORS];
    logic [15:0] zero_ofs   [MOTORS];
    logic [7:0]  gear_mask;

    fb_result_t pending_results[$];

    int mismatches = 0;
    int n_results = 0, n_frames = 0, n_captures = 0, n_clears = 0, n_ignored = 0;
    int n_saturated = 0, in_stall_cycles = 0, masks_written = 0;

    // traffic shaping knobs
    int burst_left = 0, burst_max = 16, gap_max = 0, stall_pct = 0, hold_left = 0;

    motor_feedback_multiturn_tracker uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [63:0] pack_word(logic [10:0] id, logic [2:0] mi,
                                              logic [15:0] a, logic [15:0] sp, logic [15:0] cu);
        return {2'b00, cu[7:0], cu[15:8], sp[7:0], sp[15:8], a[7:0], a[15:8], mi, id};
    endfunction

    // update the mirrored state for one accepted word and queue its result, if any
    function automatic void track_word(logic [1:0] fn, logic [63:0] w);
        logic [10:0] id;
        logic [2:0]  mi;
        int          slot, a_new, a_prev, a_ofs, t, ticks, ratio;
        longint      shaft;
        fb_result_t  r;
        id = w[10:0];
        mi = w[13:11];
        if (fn == mft_pkg::FUNC_CAPTURE || fn == mft_pkg::FUNC_CLEAR) begin
            if (fn == mft_pkg::FUNC_CAPTURE) begin
                zero_ofs[mi] = angle_seen[mi];
                n_captures++;
            end else begin
                n_clears++;
            end
            turn_cnt[mi] = 0;
            return;
        end
        if (fn != mft_pkg::FUNC_FEEDBACK || id < mft_pkg::FEEDBACK_BASE_ID ||
            int'(id) >= int'(mft_pkg::FEEDBACK_BASE_ID) + MOTORS) begin
            n_ignored++;
            return;
        end
        slot = int'(id) - int'(mft_pkg::FEEDBACK_BASE_ID);
        r.slot = slot[2:0];
        r.angle = {w[21:14], w[29:22]};
        r.speed = {w[37:30], w[45:38]};
        r.current = {w[53:46], w[61:54]};
        a_new = int'(r.angle);
        a_prev = int'(angle_seen[slot]);
        a_ofs = int'(zero_ofs[slot]);
        t = turn_cnt[slot];
        // half-turn jump test
        if (a_new - a_prev > mft_pkg::HALF_TURN) begin
            if (t > TURN_MIN) t--;
        end else if (a_new - a_prev < -mft_pkg::HALF_TURN) begin
            if (t < TURN_MAX) t++;
        end
        if (t == TURN_MAX || t == TURN_MIN) n_saturated++;
        turn_cnt[slot] = t;
        angle_seen[slot] = r.angle;
        ratio = gear_mask[slot] ? RATIO_HIGH : RATIO_LOW;
        ticks = t * TICKS_PER_TURN + a_new - a_ofs;
        // signed division truncates toward zero
        shaft = (longint'(ticks) * DEG_Q16_PER_TICK) / ratio;
        r.turn_count = t[15:0];
        r.ticks = ticks[29:0];
        r.shaft = shaft[37:0];
        pending_results.push_back(r);
        n_frames++;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 25)
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endfunction

    task automatic check_result();
        fb_result_t want;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 25)
                $display("%0t: unexpected word, expected none, actual 0x%0h", $time, m_tdata);
            return;
        end
        want = pending_results.pop_front();
        n_results++;
        check_field("motor_slot", 64'(want.slot), 64'(m_tdata[2:0]));
        check_field("encoder_angle", 64'(want.angle), 64'(m_tdata[18:3]));
        check_field("speed_rpm", 64'(want.speed), 64'(m_tdata[34:19]));
        check_field("motor_current", 64'(want.current), 64'(m_tdata[50:35]));
        check_field("turn_count", 64'(want.turn_count), 64'(m_tdata[66:51]));
        check_field("multi_turn_ticks", 64'(want.ticks), 64'(m_tdata[96:67]));
        check_field("shaft_angle_q16", 64'(want.shaft), 64'(m_tdata[134:97]));
    endtask

    // result monitor
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn) begin
                if (s_tvalid && !s_tready) in_stall_cycles++;
                if (m_tvalid && m_tready) check_result();
            end
        end
    end

    // receiver: ready in runs of random length, plus an optional long hold
    initial begin
        int run_left;
        logic run_ready;
        run_left = 0;
        run_ready = 1'b1;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    run_left = $urandom_range(1, 12);
                    run_ready = ($urandom_range(0, 99) >= stall_pct);
                end
                run_left--;
                m_tready <= run_ready;
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_word(input logic [1:0] fn, input logic [63:0] w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, burst_max);
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                s_tdata <= {$urandom, $urandom};
                s_tuser <= 2'($urandom_range(0, 3));
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= fn;
        s_tdata <= w;
        do @(posedge aclk); while (!s_tready);
        track_word(fn, w);
        @(negedge aclk);
    endtask

    task automatic send_frame(input int slot, input logic [15:0] a,
                              input logic [15:0] sp, input logic [15:0] cu);
        send_word(mft_pkg::FUNC_FEEDBACK,
                  pack_word(11'(int'(mft_pkg::FEEDBACK_BASE_ID) + slot),
                            3'($urandom_range(0, 7)), a, sp, cu));
    endtask

    task automatic send_event(input logic [1:0] fn, input int mi);
        send_word(fn, pack_word(11'($urandom_range(0, 2047)), 3'(mi), 16'($urandom),
                                16'($urandom), 16'($urandom)));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_gear(input logic [7:0] mask);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= mask;
        @(negedge aclk);
        cfg_we <= 1'b0;
        gear_mask = mask;
        masks_written++;
    endtask

    task automatic set_idling(input int gmax, input int bmax, input int spct);
        gap_max = gmax;
        burst_max = bmax;
        stall_pct = spct;
    endtask

    // field extremes on motors 0 to 3, random fields on the others, unknown identifiers and the unused func code
    task automatic test_decode_and_ids();
        int i;
        set_idling(0, 16, 0);
        write_gear(8'hA5);
        for (i = 0; i < MOTORS; i++) begin
            case (i)
                0: send_frame(i, 16'h0000, 16'h0000, 16'h0000);
                1: send_frame(i, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: send_frame(i, 16'h1FFF, 16'h8000, 16'h7FFF);
                3: send_frame(i, 16'h8000, 16'h7FFF, 16'h8000);
                default: send_frame(i, 16'($urandom), 16'($urandom), 16'($urandom));
            endcase
        end
        send_word(mft_pkg::FUNC_FEEDBACK, pack_word(11'h200, 3'd0, 16'h1234, 16'h1, 16'h2));
        send_word(mft_pkg::FUNC_FEEDBACK, pack_word(11'h209, 3'd7, 16'h1234, 16'h1, 16'h2));
        send_word(mft_pkg::FUNC_FEEDBACK, pack_word(11'h000, 3'd0, 16'hFFFF, 16'h1, 16'h2));
        send_word(mft_pkg::FUNC_FEEDBACK, pack_word(11'h7FF, 3'd7, 16'hFFFF, 16'h1, 16'h2));
        send_word(FUNC_UNUSED, pack_word(11'h201, 3'd0, 16'h4000, 16'h1, 16'h2));
    endtask

    // jump test boundaries, offset capture and turn clear
    task automatic test_unwrap_capture_clear();
        send_frame(0, 16'd0, 16'd1, 16'd1);
        send_frame(0, 16'd4096, 16'd1, 16'd1);
        send_frame(0, 16'd8193, 16'd1, 16'd1);
        send_frame(0, 16'd4097, 16'd1, 16'd1);
        send_frame(0, 16'd0, 16'd1, 16'd1);
        send_frame(0, 16'hFFFF, 16'd1, 16'd1);
        send_event(mft_pkg::FUNC_CAPTURE, 0);
        // angle below the offset gives negative ticks and a truncated shaft angle
        send_frame(0, 16'd100, 16'd1, 16'd1);
        send_event(mft_pkg::FUNC_CLEAR, 0);
        send_frame(0, 16'd100, 16'd1, 16'd1);
        send_event(mft_pkg::FUNC_CAPTURE, 7);
        send_event(mft_pkg::FUNC_CLEAR, 7);
        send_frame(7, 16'd5000, 16'd1, 16'd1);
    endtask

    // drive one motor through many turns forward, then past zero the other way
    task automatic test_turn_tracking();
        int k;
        set_idling(0, 16, 0);
        write_gear(8'h00);
        send_frame(2, 16'd0, 16'd0, 16'd0);
        for (k = 0; k < TURN_RUN; k++) begin
            send_frame(2, 16'd4096, 16'd10, 16'hFFF0);
            send_frame(2, 16'd8192, 16'd10, 16'hFFF0);
            send_frame(2, 16'd0, 16'd10, 16'hFFF0);
        end
        write_gear(8'hFF);
        send_event(mft_pkg::FUNC_CLEAR, 2);
        for (k = 0; k < TURN_RUN + 4; k++) begin
            send_frame(2, 16'd4096, 16'hFFF6, 16'd16);
            send_frame(2, 16'd0, 16'hFFF6, 16'd16);
            send_frame(2, 16'd8192, 16'hFFF6, 16'd16);
        end
    endtask

    // receiver holds off long enough that the queue fills and the input stalls
    task automatic test_backpressure();
        int k;
        wait_idle();
        set_idling(0, 16, 0);
        hold_left = 400;
        for (k = 0; k < 64; k++)
            send_frame($urandom_range(0, 7), 16'($urandom_range(0, 8191)),
                       16'($urandom), 16'($urandom));
    endtask

    task automatic random_words(input int count);
        int k, sel, slot, prev_a, next_a;
        for (k = 0; k < count; k++) begin
            sel = $urandom_range(0, 99);
            slot = $urandom_range(0, MOTORS - 1);
            if (sel < 60) begin
                // encoder-like motion, small steps with wraps through zero
                prev_a = int'(angle_seen[slot]);
                next_a = (prev_a + $urandom_range(0, 12000) - 6000) & 16'h1FFF;
                send_frame(slot, next_a[15:0], 16'($urandom), 16'($urandom));
            end else if (sel < 75) begin
                send_frame(slot, 16'($urandom), 16'($urandom), 16'($urandom));
            end else if (sel < 87) begin
                send_event(($urandom_range(0, 3) == 0) ? mft_pkg::FUNC_CAPTURE
                                                       : mft_pkg::FUNC_CLEAR, slot);
            end else if (sel < 94) begin
                send_word(2'($urandom_range(0, 3)), {$urandom, $urandom});
            end else begin
                send_word(2'($urandom_range(0, 3)),
                          pack_word(11'($urandom_range(11'h1FE, 11'h20A)), 3'($urandom),
                                    16'($urandom), 16'($urandom), 16'($urandom)));
            end
        end
    endtask

    task automatic test_random_traffic();
        logic [7:0] masks [5];
        int p;
        masks = '{8'hFF, 8'h00, 8'h5A, 8'h00, 8'h00};
        masks[3] = 8'($urandom);
        masks[4] = 8'($urandom);
        for (p = 0; p < 5; p++) begin
            write_gear(masks[p]);
            case (p)
                0: set_idling(0, 16, 0);
                1: set_idling(6, 8, 30);
                2: set_idling(2, 32, 60);
                3: set_idling(12, 4, 10);
                default: set_idling($urandom_range(0, 8), $urandom_range(1, 20),
                                    $urandom_range(0, 70));
            endcase
            random_words(RANDOM_PHASE_WORDS);
        end
    endtask

    initial begin
        int i;
        for (i = 0; i < MOTORS; i++) begin
            angle_seen[i] = '0;
            turn_cnt[i] = 0;
            zero_ofs[i] = '0;
        end
        gear_mask = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_decode_and_ids();
        test_unwrap_capture_clear();
        test_turn_tracking();
        test_backpressure();
        test_random_traffic();
        wait_idle();

        $display("checked %0d results: %0d captures, %0d clears, %0d ignored words, %0d masks",
                 n_results, n_captures, n_clears, n_ignored, masks_written);
        $display("saturated results %0d, input stall cycles %0d, mismatches %0d",
                 n_saturated, in_stall_cycles, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2500000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
